FILE: hw/rtl/hsv_range_mask_centroid_defines.svh
// ---------------------------------------------------------------------------
// hsv range mask centroid assertion macros
// shared concurrent assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef HSV_RANGE_MASK_CENTROID_DEFINES_SVH
`define HSV_RANGE_MASK_CENTROID_DEFINES_SVH

// same-cycle implication
`define HSV_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hsvrmc_pkg.sv
// ---------------------------------------------------------------------------
// hsvrmc_pkg
// shared types, widths and codes of the hsv range mask centroid block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsvrmc_pkg;

  localparam int CHAN_W      = 8;
  localparam int FRAME_W_W   = 12;
  localparam int CENTER_W    = 11;
  localparam int TALLY_W     = 23;
  localparam int SUM_W       = 34;
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 12;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam logic [CHAN_W-1:0]    CHAN_MAX      = 8'd255;
  localparam logic [FRAME_W_W-1:0] FRAME_W_RESET = 12'd640;
  localparam logic [CENTER_W-1:0]  CENTER_MAX    = 11'd2047;
  localparam logic [TALLY_W-1:0]   TALLY_MAX     = {TALLY_W{1'b1}};
  localparam logic [SUM_W-1:0]     SUM_MAX       = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_HUE_MIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_MAX     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_MAX     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MIN  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MAX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_CENTER = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 4'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
    logic              end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic                in_range;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic                center_valid;
    logic [TALLY_W-1:0]  match_count;
  } result_t;

  typedef struct packed {
    logic step;
    logic capture;
    logic div_start;
    logic div_sel_y;
    logic store_x;
    logic store_y;
    logic load_out;
    logic out_from_div;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hsvrmc_div.sv
// ---------------------------------------------------------------------------
// hsvrmc_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvrmc_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [hsvrmc_pkg::SUM_W-1:0]   dividend,
  input  wire logic [hsvrmc_pkg::TALLY_W-1:0] divisor,
  output logic      [hsvrmc_pkg::SUM_W-1:0]   quotient,
  output logic                                done
);

  localparam int SW = hsvrmc_pkg::SUM_W;
  localparam int TW = hsvrmc_pkg::TALLY_W;
  localparam int CW = hsvrmc_pkg::DIV_CNT_W;

  logic [TW-1:0] rem;
  logic [SW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [TW:0]   shifted;
  logic [TW:0]   trial;
  logic          take;

  assign shifted  = {rem, quo[SW-1]};
  assign take     = shifted >= {1'b0, divisor};
  assign trial    = shifted - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      cnt <= CW'(SW);
    end else if (busy) begin
      rem <= take ? trial[TW-1:0] : shifted[TW-1:0];
      quo <= {quo[SW-2:0], take};
      cnt <= cnt - CW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hsvrmc_datapath.sv
// ---------------------------------------------------------------------------
// hsvrmc_datapath
// range compare, raster counters, sums, centroid divide and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvrmc_datapath #(
  parameter int MAX_WIDTH  = hsvrmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hsvrmc_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [hsvrmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hsvrmc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire hsvrmc_pkg::pixel_t                pixel,
  input  wire hsvrmc_pkg::dp_cmd_t               cmd,
  output hsvrmc_pkg::dp_status_t                 status,
  output hsvrmc_pkg::result_t                    result
);

  localparam int CH   = hsvrmc_pkg::CHAN_W;
  localparam int FW   = hsvrmc_pkg::FRAME_W_W;
  localparam int SW   = hsvrmc_pkg::SUM_W;
  localparam int TW   = hsvrmc_pkg::TALLY_W;
  localparam int CTW  = hsvrmc_pkg::CENTER_W;
  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int ROWW = $clog2(MAX_HEIGHT);
  localparam int MWW  = $clog2(MAX_WIDTH + 1);
  localparam int WW   = (MWW > FW) ? MWW : FW;

  logic [CH-1:0] hue_min;
  logic [CH-1:0] hue_max;
  logic [CH-1:0] sat_min;
  logic [CH-1:0] sat_max;
  logic [CH-1:0] bright_min;
  logic [CH-1:0] bright_max;
  logic          find_center;
  logic [FW-1:0] frame_width;

  logic [COLW-1:0] column_counter;
  logic [ROWW-1:0] row_counter;
  logic [TW-1:0]   pixel_tally;
  logic [SW-1:0]   column_sum;
  logic [SW-1:0]   row_sum;

  logic            cap_match;
  logic [TW-1:0]   cap_tally;
  logic [SW-1:0]   cap_col_sum;
  logic [SW-1:0]   cap_row_sum;
  logic [CTW-1:0]  cx;
  logic [CTW-1:0]  cy;

  logic            match;
  logic            acc;
  logic [TW-1:0]   tally_next;
  logic [SW-1:0]   col_sum_next;
  logic [SW-1:0]   row_sum_next;
  logic [SW:0]     col_add;
  logic [SW:0]     row_add;
  logic [WW-1:0]   width_eff;
  logic [WW-1:0]   col_plus;
  logic [SW-1:0]   quotient;
  logic [CTW-1:0]  quo_clamped;
  logic            div_done;
  hsvrmc_pkg::result_t direct;
  hsvrmc_pkg::result_t from_div;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_min     <= '0;
      hue_max     <= hsvrmc_pkg::CHAN_MAX;
      sat_min     <= '0;
      sat_max     <= hsvrmc_pkg::CHAN_MAX;
      bright_min  <= '0;
      bright_max  <= hsvrmc_pkg::CHAN_MAX;
      find_center <= 1'b1;
      frame_width <= hsvrmc_pkg::FRAME_W_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hsvrmc_pkg::REG_HUE_MIN:     hue_min     <= cfg_data[CH-1:0];
        hsvrmc_pkg::REG_HUE_MAX:     hue_max     <= cfg_data[CH-1:0];
        hsvrmc_pkg::REG_SAT_MIN:     sat_min     <= cfg_data[CH-1:0];
        hsvrmc_pkg::REG_SAT_MAX:     sat_max     <= cfg_data[CH-1:0];
        hsvrmc_pkg::REG_BRIGHT_MIN:  bright_min  <= cfg_data[CH-1:0];
        hsvrmc_pkg::REG_BRIGHT_MAX:  bright_max  <= cfg_data[CH-1:0];
        hsvrmc_pkg::REG_FIND_CENTER: find_center <= cfg_data[0];
        hsvrmc_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data[FW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign match = (pixel.hue >= hue_min) && (pixel.hue <= hue_max)
              && (pixel.saturation >= sat_min) && (pixel.saturation <= sat_max)
              && (pixel.brightness >= bright_min) && (pixel.brightness <= bright_max);
  assign acc = match && find_center;

  assign col_add = {1'b0, column_sum} + (SW + 1)'(column_counter);
  assign row_add = {1'b0, row_sum} + (SW + 1)'(row_counter);

  always_comb begin
    tally_next   = pixel_tally;
    col_sum_next = column_sum;
    row_sum_next = row_sum;
    if (acc) begin
      tally_next   = (pixel_tally == hsvrmc_pkg::TALLY_MAX) ? pixel_tally
                                                            : pixel_tally + TW'(1);
      col_sum_next = col_add[SW] ? hsvrmc_pkg::SUM_MAX : col_add[SW-1:0];
      row_sum_next = row_add[SW] ? hsvrmc_pkg::SUM_MAX : row_add[SW-1:0];
    end
  end

  // zero width acts as one, oversize width as the maximum
  always_comb begin
    if (frame_width == '0) begin
      width_eff = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width);
    end
  end
  assign col_plus = WW'(column_counter) + WW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      pixel_tally    <= '0;
      column_sum     <= '0;
      row_sum        <= '0;
    end else if (cmd.step) begin
      if (pixel.end_of_frame) begin
        column_counter <= '0;
        row_counter    <= '0;
        pixel_tally    <= '0;
        column_sum     <= '0;
        row_sum        <= '0;
      end else begin
        pixel_tally <= tally_next;
        column_sum  <= col_sum_next;
        row_sum     <= row_sum_next;
        if (col_plus >= width_eff) begin
          column_counter <= '0;
          if (row_counter != ROWW'(MAX_HEIGHT - 1)) begin
            row_counter <= row_counter + ROWW'(1);
          end
        end else begin
          column_counter <= col_plus[COLW-1:0];
        end
      end
    end
  end

  assign status.need_div = pixel.end_of_frame && find_center && (tally_next != '0);
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_match   <= match;
      cap_tally   <= tally_next;
      cap_col_sum <= col_sum_next;
      cap_row_sum <= row_sum_next;
    end
  end

  hsvrmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel_y ? cap_row_sum : cap_col_sum),
    .divisor  (cap_tally),
    .quotient (quotient),
    .done     (div_done)
  );

  assign quo_clamped = (|quotient[SW-1:CTW]) ? hsvrmc_pkg::CENTER_MAX : quotient[CTW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.store_x) begin
      cx <= quo_clamped;
    end
    if (cmd.store_y) begin
      cy <= quo_clamped;
    end
  end

  always_comb begin
    direct              = '0;
    direct.in_range     = match;
    direct.match_count  = pixel.end_of_frame ? tally_next : '0;
    from_div.in_range     = cap_match;
    from_div.center_x     = cx;
    from_div.center_y     = cy;
    from_div.center_valid = 1'b1;
    from_div.match_count  = cap_tally;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result <= cmd.out_from_div ? from_div : direct;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hsvrmc_ctrl.sv
// ---------------------------------------------------------------------------
// hsvrmc_ctrl
// sequencer for pixel transactions, centroid divide and result handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_range_mask_centroid_defines.svh"

module hsvrmc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pixel_valid,
  output logic                        pixel_stall,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  input  wire hsvrmc_pkg::dp_status_t status,
  output hsvrmc_pkg::dp_cmd_t         cmd
);

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_XGO   = 3'd1;
  localparam logic [2:0] ST_XWAIT = 3'd2;
  localparam logic [2:0] ST_YGO   = 3'd3;
  localparam logic [2:0] ST_YWAIT = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_busy;
  logic       accept;

  assign out_busy    = result_valid && result_stall;
  assign pixel_stall = (state != ST_RUN) || out_busy;
  assign accept      = pixel_valid && !pixel_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_RUN: begin
        cmd.step = accept;
        if (accept) begin
          if (status.need_div) begin
            cmd.capture = 1'b1;
            state_next  = ST_XGO;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      ST_XGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (status.div_done) begin
          cmd.store_x = 1'b1;
          state_next  = ST_YGO;
        end
      end
      ST_YGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_next    = ST_YWAIT;
      end
      ST_YWAIT: begin
        if (status.div_done) begin
          cmd.store_y = 1'b1;
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_busy) begin
          cmd.load_out     = 1'b1;
          cmd.out_from_div = 1'b1;
          state_next       = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `HSV_ASSERT_IMPL(a_stall_while_busy, clk, rst, state != ST_RUN, pixel_stall, "pixel taken during centroid divide")
  `HSV_ASSERT_IMPL(a_no_overwrite, clk, rst, result_valid && result_stall, !cmd.load_out, "waiting result overwritten")
  `HSV_ASSERT_NEXT(a_div_entry, clk, rst, cmd.capture, state == ST_XGO, "frame end did not start divide")
  `HSV_ASSERT_IMPL(a_done_when_waiting, clk, rst, status.div_done, state == ST_XWAIT || state == ST_YWAIT, "divider done outside wait")

endmodule

`default_nettype wire

FILE: hw/rtl/hsv_range_mask_centroid.sv
// ---------------------------------------------------------------------------
// hsv_range_mask_centroid
// hsv range mask with per-frame centroid of matching pixels
// ---------------------------------------------------------------------------
//
//  channel   signals                               handshake
//  pixel     pixel_valid, pixel_stall, pixel       valid / stall
//  result    result_valid, result_stall, result    valid / stall
//  cfg       cfg_valid, cfg_ready, cfg_index/data  valid / ready
//
//  one pixel per cycle outside a divide; the result register lets the next
//  pixel in while a result waits, as long as that result is taken in the same
//  cycle; a frame end pixel with centre finding on and a nonzero tally stalls
//  pixels: the shared 34-step restoring divider runs once for x, once for y
//  reset restores register defaults and clears counters and sums, no sweep
//  configuration writes are always taken
//
`timescale 1ns / 1ps
`default_nettype none

module hsv_range_mask_centroid #(
  parameter int MAX_WIDTH  = hsvrmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hsvrmc_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pixel_valid,
  output logic                                   pixel_stall,
  input  wire hsvrmc_pkg::pixel_t                pixel,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output hsvrmc_pkg::result_t                    result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hsvrmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hsvrmc_pkg::CFG_DATA_W-1:0] cfg_data
);

  hsvrmc_pkg::dp_cmd_t    cmd;
  hsvrmc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  hsvrmc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  hsvrmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

endmodule

`default_nettype wire

FILE: tb/hsv_range_mask_centroid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_range_mask_centroid_checker
// Watches the pixel, result and register channels of the block. It keeps its
// own copy of the range registers, the raster position and the per-frame
// sums. From these it works out the mask bit and the frame-end centroid of
// every accepted pixel. It compares each accepted result field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hsv_range_mask_centroid_checker
  import hsvrmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  input  logic                  pixel_stall,
  input  pixel_t                pixel,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  logic [CHAN_W-1:0]    hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
  logic                 centre_on;
  logic [FRAME_W_W-1:0] row_len;

  logic [CENTER_W-1:0]  col_pos, row_pos;
  logic [TALLY_W-1:0]   match_tally;
  logic [SUM_W-1:0]     col_total, row_total;

  result_t              centroid_q[$];
  int                   results_seen;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch on result %0d: %s", $time, results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [TALLY_W-1:0] got,
                             input logic [TALLY_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic logic [SUM_W-1:0] add_capped(input logic [SUM_W-1:0] acc,
                                                  input logic [CENTER_W-1:0] pos);
    logic [SUM_W:0] total;
    total = {1'b0, acc} + (SUM_W + 1)'(pos);
    return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
  endfunction

  function automatic result_t compute_mask_centroid(input pixel_t px);
    result_t          r;
    logic             hit;
    int               span;
    logic [SUM_W-1:0] qx, qy;
    r = '0;
    hit = (px.hue >= hue_lo) && (px.hue <= hue_hi) &&
          (px.saturation >= sat_lo) && (px.saturation <= sat_hi) &&
          (px.brightness >= val_lo) && (px.brightness <= val_hi);
    r.in_range = hit;
    if (hit && centre_on) begin
      if (match_tally != TALLY_MAX) match_tally = match_tally + TALLY_W'(1);
      col_total = add_capped(col_total, col_pos);
      row_total = add_capped(row_total, row_pos);
    end
    if (px.end_of_frame) begin
      r.match_count = match_tally;
      if (centre_on && match_tally != '0) begin
        qx = col_total / SUM_W'(match_tally);
        qy = row_total / SUM_W'(match_tally);
        r.center_x = (qx > SUM_W'(CENTER_MAX)) ? CENTER_MAX : qx[CENTER_W-1:0];
        r.center_y = (qy > SUM_W'(CENTER_MAX)) ? CENTER_MAX : qy[CENTER_W-1:0];
        r.center_valid = 1'b1;
      end
      col_pos = '0;
      row_pos = '0;
      match_tally = '0;
      col_total = '0;
      row_total = '0;
    end else begin
      // zero width acts as one, oversize widths are held to the maximum
      span = (row_len == '0) ? 1 :
             (int'(row_len) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(row_len);
      if (int'(col_pos) + 1 >= span) begin
        col_pos = '0;
        if (int'(row_pos) + 1 < MAX_HEIGHT_DEF) row_pos = row_pos + CENTER_W'(1);
      end else begin
        col_pos = col_pos + CENTER_W'(1);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      hue_lo = '0;
      hue_hi = CHAN_MAX;
      sat_lo = '0;
      sat_hi = CHAN_MAX;
      val_lo = '0;
      val_hi = CHAN_MAX;
      centre_on = 1'b1;
      row_len = FRAME_W_RESET;
      col_pos = '0;
      row_pos = '0;
      match_tally = '0;
      col_total = '0;
      row_total = '0;
      centroid_q.delete();
    end else begin
      // results leave before the pixel of this edge is predicted
      if (result_valid && !result_stall) begin
        if (centroid_q.size() == 0) begin
          report_mismatch("result with no pixel outstanding");
        end else begin
          want = centroid_q.pop_front();
          check_field("in_range", TALLY_W'(result.in_range), TALLY_W'(want.in_range));
          check_field("center_x", TALLY_W'(result.center_x), TALLY_W'(want.center_x));
          check_field("center_y", TALLY_W'(result.center_y), TALLY_W'(want.center_y));
          check_field("center_valid", TALLY_W'(result.center_valid),
                      TALLY_W'(want.center_valid));
          check_field("match_count", result.match_count, want.match_count);
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HUE_MIN:     hue_lo = cfg_data[CHAN_W-1:0];
          REG_HUE_MAX:     hue_hi = cfg_data[CHAN_W-1:0];
          REG_SAT_MIN:     sat_lo = cfg_data[CHAN_W-1:0];
          REG_SAT_MAX:     sat_hi = cfg_data[CHAN_W-1:0];
          REG_BRIGHT_MIN:  val_lo = cfg_data[CHAN_W-1:0];
          REG_BRIGHT_MAX:  val_hi = cfg_data[CHAN_W-1:0];
          REG_FIND_CENTER: centre_on = cfg_data[0];
          REG_FRAME_WIDTH: row_len = cfg_data[FRAME_W_W-1:0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) begin
        centroid_q.push_back(compute_mask_centroid(pixel));
      end
    end
    pending <= centroid_q.size();
  end

endmodule

FILE: tb/tb_hsv_range_mask_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_range_mask_centroid
// Drives HSV pixel frames into the range mask and centroid block, and stalls
// its result channel at random. The register settings change between
// phases, sometimes while a frame is still open. A short directed section
// comes first: range edges, empty frames, centre finding off and an empty
// range. Random frames follow, plus one long frame at one pixel per row.
// The checker module does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_hsv_range_mask_centroid;
  import hsvrmc_pkg::*;

  localparam int PIXEL_TARGET   = 1850;
  localparam int LONG_FRAME_LEN = 400;
  localparam int IDLE_PCT       = 14;
  localparam int QUIET_LIMIT    = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  pixel_t                pixel = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    mismatches;
  int                    pending;
  int                    idle_pct = IDLE_PCT;
  int                    pixels_sent = 0;
  int                    quiet_cycles = 0;
  logic [CHAN_W-1:0]     bound_lo [3];
  logic [CHAN_W-1:0]     bound_hi [3];

  hsv_range_mask_centroid DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  hsv_range_mask_centroid_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic pixel_t pixel_of(input logic [CHAN_W-1:0] h, input logic [CHAN_W-1:0] s,
                                      input logic [CHAN_W-1:0] v, input logic last);
    pixel_t p;
    p.hue = h;
    p.saturation = s;
    p.brightness = v;
    p.end_of_frame = last;
    return p;
  endfunction

  // mostly inside the programmed window, with its edges and near misses
  function automatic logic [CHAN_W-1:0] pick_channel(input logic [CHAN_W-1:0] lo,
                                                     input logic [CHAN_W-1:0] hi);
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return lo;
    if (sel < 10) return hi;
    if (sel < 14) return lo - CHAN_W'(1);
    if (sel < 18) return hi + CHAN_W'(1);
    if (sel < 90 && lo <= hi) return CHAN_W'($urandom_range(hi, lo));
    return CHAN_W'($urandom);
  endfunction

  function automatic pixel_t make_pixel(input logic last);
    return pixel_of(pick_channel(bound_lo[0], bound_hi[0]),
                    pick_channel(bound_lo[1], bound_hi[1]),
                    pick_channel(bound_lo[2], bound_hi[2]), last);
  endfunction

  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic wait_until_idle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper data bits are filled with noise
  task automatic program_registers(input logic centre_on, input logic [FRAME_W_W-1:0] width);
    write_reg(REG_HUE_MIN, {4'($urandom), bound_lo[0]});
    write_reg(REG_HUE_MAX, {4'($urandom), bound_hi[0]});
    write_reg(REG_SAT_MIN, {4'($urandom), bound_lo[1]});
    write_reg(REG_SAT_MAX, {4'($urandom), bound_hi[1]});
    write_reg(REG_BRIGHT_MIN, {4'($urandom), bound_lo[2]});
    write_reg(REG_BRIGHT_MAX, {4'($urandom), bound_hi[2]});
    write_reg(REG_FIND_CENTER, {11'($urandom), centre_on});
    if ($urandom_range(99) < 25) begin
      write_reg(REG_FRAME_WIDTH + 4'($urandom_range(1, 8)), 12'($urandom));
    end
    write_reg(REG_FRAME_WIDTH, width);
    cfg_valid <= 1'b0;
  endtask

  task automatic randomise_settings();
    logic [CHAN_W-1:0]    a, b;
    logic [FRAME_W_W-1:0] width;
    int                   sel;
    for (int c = 0; c < 3; c++) begin
      a = CHAN_W'($urandom);
      b = CHAN_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 15) begin
        bound_lo[c] = '0;
        bound_hi[c] = CHAN_MAX;
      end else if (sel < 27) begin
        bound_lo[c] = (a > b) ? a : b;
        bound_hi[c] = (a > b) ? b : a;
      end else begin
        bound_lo[c] = (a > b) ? b : a;
        bound_hi[c] = (a > b) ? a : b;
      end
    end
    sel = $urandom_range(99);
    if (sel < 80) width = FRAME_W_W'($urandom_range(1, 12));
    else if (sel < 85) width = '0;
    else if (sel < 90) width = FRAME_W_W'(MAX_WIDTH_DEF);
    else if (sel < 93) width = '1;
    else if (sel < 96) width = FRAME_W_W'(MAX_WIDTH_DEF - 1);
    else width = FRAME_W_W'($urandom);
    program_registers($urandom_range(99) < 80, width);
  endtask

  initial begin
    int phase;
    int n_frames;
    int len;
    int random_goal;
    bit leave_open;

    bound_lo = '{8'd0, 8'd0, 8'd0};
    bound_hi = '{CHAN_MAX, CHAN_MAX, CHAN_MAX};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: full window, centre on, 640 wide
    send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(pixel_of(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0));
    send_pixel(pixel_of(8'h5a, 8'ha5, 8'h3c, 1'b1));
    wait_until_idle();

    bound_lo = '{8'd10, 8'd30, 8'd50};
    bound_hi = '{8'd20, 8'd40, 8'd60};
    program_registers(1'b1, 12'd3);
    send_pixel(pixel_of(8'd10, 8'd30, 8'd50, 1'b0));
    send_pixel(pixel_of(8'd20, 8'd40, 8'd60, 1'b0));
    send_pixel(pixel_of(8'd9, 8'd35, 8'd55, 1'b0));
    send_pixel(pixel_of(8'd21, 8'd35, 8'd55, 1'b0));
    send_pixel(pixel_of(8'd15, 8'd29, 8'd55, 1'b0));
    send_pixel(pixel_of(8'd15, 8'd41, 8'd55, 1'b0));
    send_pixel(pixel_of(8'd15, 8'd35, 8'd49, 1'b0));
    send_pixel(pixel_of(8'd15, 8'd35, 8'd61, 1'b0));
    send_pixel(pixel_of(8'd15, 8'd35, 8'd55, 1'b1));
    // frame end with nothing matched
    send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b1));
    wait_until_idle();

    program_registers(1'b0, 12'd3);
    send_pixel(pixel_of(8'd15, 8'd35, 8'd55, 1'b0));
    send_pixel(pixel_of(8'd15, 8'd35, 8'd55, 1'b1));
    wait_until_idle();

    // hue window inverted: nothing can match
    bound_lo = '{8'd200, 8'd35, 8'd55};
    bound_hi = '{8'd100, 8'd35, 8'd55};
    program_registers(1'b1, 12'd0);
    send_pixel(pixel_of(8'd150, 8'd35, 8'd55, 1'b0));
    send_pixel(pixel_of(8'd100, 8'd35, 8'd55, 1'b0));
    send_pixel(pixel_of(8'd200, 8'd35, 8'd55, 1'b1));
    wait_until_idle();

    random_goal = PIXEL_TARGET;
    phase = 0;
    while (pixels_sent < random_goal) begin
      idle_pct = (phase >= 4 && phase < 9) ? 0 : IDLE_PCT;
      if (phase == 12) begin
        // one row per pixel through a long frame
        bound_lo = '{8'd0, 8'd0, 8'd0};
        bound_hi = '{CHAN_MAX, CHAN_MAX, CHAN_MAX};
        program_registers(1'b1, 12'd0);
        for (int k = 0; k < LONG_FRAME_LEN; k++) begin
          send_pixel(make_pixel(k == LONG_FRAME_LEN - 1));
        end
      end else begin
        randomise_settings();
        n_frames = $urandom_range(1, 5);
        leave_open = 1'($urandom_range(1));
        for (int f = 0; f < n_frames; f++) begin
          len = ($urandom_range(99) < 10) ? 1 : $urandom_range(2, 40);
          for (int k = 0; k < len; k++) begin
            send_pixel(make_pixel((k == len - 1 && !(leave_open && f == n_frames - 1)) ||
                                  $urandom_range(99) < 2));
          end
        end
      end
      wait_until_idle();
      phase++;
    end

    idle_pct = IDLE_PCT;
    wait_until_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: hsv_range_mask_centroid.f
+incdir+hw/rtl
hw/rtl/hsvrmc_pkg.sv
hw/rtl/hsvrmc_div.sv
hw/rtl/hsvrmc_datapath.sv
hw/rtl/hsvrmc_ctrl.sv
hw/rtl/hsv_range_mask_centroid.sv
tb/hsv_range_mask_centroid_checker.sv
tb/tb_hsv_range_mask_centroid.sv
